/* design/great_circle_bearing_assert.svh */
// Assertion helpers for the bearing pipeline.
`ifndef GREAT_CIRCLE_BEARING_ASSERT_SVH
`define GREAT_CIRCLE_BEARING_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GCB_ASSERT_IMPL(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define GCB_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

/* design/gcb_pkg.sv */
package gcb_pkg;

  localparam int UW = 28;   // reduced-angle input width (signed)
  localparam int SW = 34;   // sine/cosine width, Q4.30
  localparam int VW = 36;   // vectoring x/y width

  localparam logic [26:0] FULL_UNITS = 27'd129600000;
  localparam logic [26:0] HALF_UNITS = 27'd64800000;
  localparam logic [31:0] HALF_BIN32 = 32'h8000_0000;
  localparam logic signed [32:0] QUARTER_BIN = 33'sd1073741824;
  localparam logic signed [SW-1:0] CORDIC_ONE = 34'sd652032874;

  // Constants of the unit-to-binary-angle conversion
  localparam logic [15:0] CONV_MUL = 16'd35483;
  localparam logic [16:0] CONV_RND = 17'd126562;
  localparam logic [17:0] CONV_DIV = 18'd253125;
  localparam logic [25:0] CONV_RCP = 26'd34749997;

  localparam logic [31:0] ATAN_BIN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic vld;
    logic special;   // equal longitudes
    logic half;      // first latitude larger
    logic mode;      // initial bearing
  } side_t;

endpackage

/* design/gcb_to_bin.sv */
module gcb_to_bin (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  logic signed [gcb_pkg::UW-1:0] u,
  output logic                          out_vld,
  output logic signed [31:0]            b
);

  logic [3:0] vld;
  logic signed [28:0] ue;
  logic signed [28:0] rr;
  logic [26:0] r1, r2, r3, r4;
  logic [42:0] p3_2, p3_3;
  logic [50:0] qprod;
  logic [24:0] q3, q4;
  logic [42:0] qd;
  logic [19:0] rem;
  logic [1:0]  corr;
  logic [32:0] r33;

  // Bring the angle into one full circle.
  always_comb begin
    ue = 29'(u);
    if (ue < -$signed({2'b0, gcb_pkg::FULL_UNITS})) begin
      rr = ue + $signed({1'b0, gcb_pkg::FULL_UNITS, 1'b0});
    end else if (ue < 0) begin
      rr = ue + $signed({2'b0, gcb_pkg::FULL_UNITS});
    end else if (ue >= $signed({2'b0, gcb_pkg::FULL_UNITS})) begin
      rr = ue - $signed({2'b0, gcb_pkg::FULL_UNITS});
    end else begin
      rr = ue;
    end
  end

  // Estimate the quotient low, then fix it up from the remainder.
  assign qprod = 51'(p3_2[42:18]) * 51'(gcb_pkg::CONV_RCP);
  assign qd    = 43'(q3) * 43'(gcb_pkg::CONV_DIV);

  always_comb begin
    if (rem >= 20'(3 * gcb_pkg::CONV_DIV)) begin
      corr = 2'd3;
    end else if (rem >= 20'(2 * gcb_pkg::CONV_DIV)) begin
      corr = 2'd2;
    end else if (rem >= 20'(gcb_pkg::CONV_DIV)) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    r33 = {1'b0, r4, 5'b0} + 33'(r4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else begin
      vld     <= {vld[2:0], in_vld};
      out_vld <= vld[3];
    end
    r1   <= rr[26:0];
    r2   <= r1;
    p3_2 <= 43'(r1) * 43'(gcb_pkg::CONV_MUL) + 43'(gcb_pkg::CONV_RND);
    r3   <= r2;
    p3_3 <= p3_2;
    q3   <= qprod[49:25];
    r4   <= r3;
    q4   <= q3;
    rem  <= 20'(p3_3 - qd);
    b    <= $signed(r33[31:0] + 32'(q4) + 32'(corr));
  end

endmodule

/* design/gcb_sincos.sv */
module gcb_sincos #(
  parameter int STAGES = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  logic signed [31:0]            z,
  output logic                          out_vld,
  output logic signed [gcb_pkg::SW-1:0] c,
  output logic signed [gcb_pkg::SW-1:0] s
);

  logic signed [gcb_pkg::SW-1:0] xs [STAGES+1];
  logic signed [gcb_pkg::SW-1:0] ys [STAGES+1];
  logic signed [32:0]            zs [STAGES+1];
  logic [STAGES:0]               ng;
  logic [STAGES:0]               vs;
  logic signed [32:0]            ze;

  assign ze = 33'(z);

  // Fold the angle into the right half plane.
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= in_vld;
    end
    xs[0] <= gcb_pkg::CORDIC_ONE;
    ys[0] <= '0;
    if (ze > gcb_pkg::QUARTER_BIN) begin
      zs[0] <= ze - 33'sh0_8000_0000;
      ng[0] <= 1'b1;
    end else if (ze < -gcb_pkg::QUARTER_BIN) begin
      zs[0] <= ze + 33'sh0_8000_0000;
      ng[0] <= 1'b1;
    end else begin
      zs[0] <= ze;
      ng[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else begin
        vs[i+1] <= vs[i];
      end
      ng[i+1] <= ng[i];
      if (zs[i] >= 0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - $signed({1'b0, gcb_pkg::ATAN_BIN[i]});
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + $signed({1'b0, gcb_pkg::ATAN_BIN[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vs[STAGES];
    end
    c <= ng[STAGES] ? -xs[STAGES] : xs[STAGES];
    s <= ng[STAGES] ? -ys[STAGES] : ys[STAGES];
  end

endmodule

/* design/gcb_atan2.sv */
module gcb_atan2 #(
  parameter int STAGES = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  logic signed [gcb_pkg::VW-1:0] x,
  input  logic signed [gcb_pkg::VW-1:0] y,
  output logic                          out_vld,
  output logic [31:0]                   z
);

  logic signed [gcb_pkg::VW-1:0] xs [STAGES+1];
  logic signed [gcb_pkg::VW-1:0] ys [STAGES+1];
  logic signed [33:0]            zs [STAGES+1];
  logic [STAGES:0]               zf;
  logic [STAGES:0]               vs;

  // Turn a left-half-plane vector by a quarter circle first.
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= in_vld;
    end
    zf[0] <= (x == 0) && (y == 0);
    if (x < 0) begin
      if (y >= 0) begin
        xs[0] <= y;
        ys[0] <= -x;
        zs[0] <= 34'(gcb_pkg::QUARTER_BIN);
      end else begin
        xs[0] <= -y;
        ys[0] <= x;
        zs[0] <= -34'(gcb_pkg::QUARTER_BIN);
      end
    end else begin
      xs[0] <= x;
      ys[0] <= y;
      zs[0] <= '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else begin
        vs[i+1] <= vs[i];
      end
      zf[i+1] <= zf[i];
      if (ys[i] < 0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - $signed({2'b0, gcb_pkg::ATAN_BIN[i]});
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + $signed({2'b0, gcb_pkg::ATAN_BIN[i]});
      end
    end
  end

  assign out_vld = vs[STAGES];
  assign z       = zf[STAGES] ? 32'd0 : zs[STAGES][31:0];

endmodule

/* design/great_circle_bearing.sv */
// Channel  | Ports                                      | Handshake
// ---------+--------------------------------------------+---------------------------
// request  | lat_from lon_from lat_to lon_to initial_mode | start, taken when !busy
// result   | bearing                                    | done, one-cycle strobe
//
// One item may enter every cycle; busy stays low.
// From accept to done an item passes the input stage, the angle conversion, the
// rotation CORDIC pipelines, the products, the vectoring CORDIC and the output.
// Synchronous reset clears all valid bits; items in flight are dropped.
// The receiver cannot stall; each result shows for exactly one cycle.
`include "great_circle_bearing_assert.svh"

module great_circle_bearing #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [25:0] lat_from,
  input  logic signed [26:0] lon_from,
  input  logic signed [25:0] lat_to,
  input  logic signed [26:0] lon_to,
  input  logic               initial_mode,
  output logic               done,
  output logic [26:0]        bearing
);

  localparam int LAT = 2 * CORDIC_STAGES + 11;
  localparam int UW  = gcb_pkg::UW;
  localparam int SW  = gcb_pkg::SW;
  localparam int VW  = gcb_pkg::VW;

  gcb_pkg::side_t side0;
  gcb_pkg::side_t side_q [LAT];
  gcb_pkg::side_t side_o1;
  logic signed [UW-1:0] ua, ub, ud;

  logic        bv_a, bv_b, bv_d;
  logic signed [31:0] ba, bb, bd;
  logic        sv_a, sv_b, sv_d;
  logic signed [SW-1:0] ca, sa, cb, sb, cd, sd;

  logic signed [2*SW-1:0] m_yy, m_a, m_m;
  logic signed [VW+SW-1:0] m_t;
  logic        pv1, pv2, pv3;
  logic signed [VW-1:0] yy1, a1, mm1, cd1;
  logic signed [VW-1:0] yy2, a2, t2;
  logic signed [VW-1:0] yy3, xx3;

  logic        at_vld;
  logic [31:0] at_z;
  logic [31:0] b32;
  logic [58:0] prod;
  logic [59:0] rnd;
  logic [26:0] units;

  assign busy = 1'b0;

  // Input stage: pick roles by mode, flag equal longitudes.
  always_ff @(posedge clk) begin
    if (rst) begin
      side0.vld <= 1'b0;
    end else begin
      side0.vld <= start;
    end
    side0.special <= (lon_from == lon_to);
    side0.half    <= (lat_from > lat_to);
    side0.mode    <= initial_mode;
    if (initial_mode) begin
      ua <= UW'(lat_from);
      ub <= UW'(lat_to);
      ud <= UW'(lon_to) - UW'(lon_from);
    end else begin
      ua <= UW'(lat_to);
      ub <= UW'(lat_from);
      ud <= UW'(lon_from) - UW'(lon_to);
    end
  end

  gcb_to_bin u_bin_a (.clk, .rst, .in_vld(side0.vld), .u(ua), .out_vld(bv_a), .b(ba));
  gcb_to_bin u_bin_b (.clk, .rst, .in_vld(side0.vld), .u(ub), .out_vld(bv_b), .b(bb));
  gcb_to_bin u_bin_d (.clk, .rst, .in_vld(side0.vld), .u(ud), .out_vld(bv_d), .b(bd));

  gcb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_a (
    .clk, .rst, .in_vld(bv_a), .z(ba), .out_vld(sv_a), .c(ca), .s(sa)
  );
  gcb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_b (
    .clk, .rst, .in_vld(bv_b), .z(bb), .out_vld(sv_b), .c(cb), .s(sb)
  );
  gcb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_d (
    .clk, .rst, .in_vld(bv_d), .z(bd), .out_vld(sv_d), .c(cd), .s(sd)
  );

  // Products, one multiplier deep per stage.
  assign m_yy = cb * sd;
  assign m_a  = sb * ca;
  assign m_m  = sa * cb;
  assign m_t  = mm1 * $signed(cd1[SW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv1 <= 1'b0;
      pv2 <= 1'b0;
      pv3 <= 1'b0;
    end else begin
      pv1 <= sv_a & sv_b & sv_d;
      pv2 <= pv1;
      pv3 <= pv2;
    end
    yy1 <= m_yy[VW+29:30];
    a1  <= m_a[VW+29:30];
    mm1 <= m_m[VW+29:30];
    cd1 <= VW'(cd);
    yy2 <= yy1;
    a2  <= a1;
    t2  <= m_t[VW+29:30];
    yy3 <= yy2;
    xx3 <= a2 - t2;
  end

  gcb_atan2 #(.STAGES(CORDIC_STAGES)) u_atan (
    .clk, .rst, .in_vld(pv3), .x(xx3), .y(yy3), .out_vld(at_vld), .z(at_z)
  );

  // Side information rides alongside the arithmetic.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        side_q[k] <= '0;
      end
    end else begin
      side_q[0] <= side0;
      for (int k = 1; k < LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Back to units: add half a circle in final mode, scale, round.
  assign b32   = at_z + (side_q[LAT-1].mode ? 32'd0 : gcb_pkg::HALF_BIN32);
  assign rnd   = 60'(prod) + 60'h0_8000_0000;
  assign units = rnd[58:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      side_o1.vld <= 1'b0;
      done        <= 1'b0;
    end else begin
      side_o1.vld <= side_q[LAT-1].vld;
      done        <= side_o1.vld;
    end
    side_o1.special <= side_q[LAT-1].special;
    side_o1.half    <= side_q[LAT-1].half;
    side_o1.mode    <= side_q[LAT-1].mode;
    prod            <= 59'(b32) * 59'(gcb_pkg::FULL_UNITS);
    if (side_o1.special) begin
      bearing <= side_o1.half ? gcb_pkg::HALF_UNITS : 27'd0;
    end else if (units >= gcb_pkg::FULL_UNITS) begin
      bearing <= 27'd0;
    end else begin
      bearing <= units;
    end
  end

  `GCB_ASSERT_IMPL(a_range, clk, rst, done, bearing < gcb_pkg::FULL_UNITS, "bearing out of range")
  `GCB_ASSERT_IMPL(a_align_f, clk, rst, at_vld, side_q[LAT-1].vld, "atan without side data")
  `GCB_ASSERT_IMPL(a_align_r, clk, rst, side_q[LAT-1].vld, at_vld, "side data without atan")
  `GCB_ASSERT_IMPL(a_pairs, clk, rst, sv_a, sv_b && sv_d, "sincos lanes out of step")
  `GCB_ASSERT_IMPL(a_bin_pairs, clk, rst, bv_a, bv_b && bv_d, "angle lanes out of step")

endmodule
